// ===== src/hpet_pkg.sv =====
// shared types and constants for the event-timer register block
`default_nettype none
package hpet_pkg;
  localparam int NUM_TIMERS = 3;
  localparam int TW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  localparam logic [7:0] A_CAP    = 8'h00;
  localparam logic [7:0] A_PERIOD = 8'h01;
  localparam logic [7:0] A_GCFG   = 8'h04;
  localparam logic [7:0] A_ISR    = 8'h08;
  localparam logic [7:0] A_CNT_LO = 8'h3C;
  localparam logic [7:0] A_CNT_HI = 8'h3D;
  localparam logic [7:0] A_TIMER0 = 8'h40;

  localparam logic [2:0] R_CFG    = 3'd0;
  localparam logic [2:0] R_CMP_LO = 3'd2;
  localparam logic [2:0] R_CMP_HI = 3'd3;

  localparam logic [0:0] CFG_IDX_PERIOD = 1'b0;
  localparam logic [0:0] CFG_IDX_VENDOR = 1'b1;

  // decoded command from the front part
  typedef enum logic [3:0] {
    K_NONE, K_TICK, K_RD_CAP, K_RD_PERIOD, K_RD_GCFG, K_RD_ISR, K_RD_CNT_LO,
    K_RD_CNT_HI, K_RD_TCFG, K_RD_CMP_LO, K_RD_CMP_HI, K_WR_GCFG, K_WR_ISR,
    K_WR_CNT, K_WR_TCFG, K_WR_CMP
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [TW-1:0] timer;
    logic        high;
    logic [31:0] data;
  } cmd_t;
endpackage
`default_nettype wire

// ===== src/hpet_front.sv =====
// front part: accepts beats, decodes address into a command, two-entry queue
`default_nettype none
module hpet_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire logic [47:0]       s_tdata,
  output logic                   q_valid,
  input  wire logic              q_ready,
  output hpet_pkg::cmd_t         q_cmd
);
  import hpet_pkg::*;

  logic [1:0]  op;
  logic [7:0]  addr;
  logic [31:0] wdata;
  logic [7:0]  toff;
  logic [4:0]  tnum;
  logic [2:0]  treg;
  cmd_t        dec;
  cmd_t        q [2];
  logic        rd_ptr, wr_ptr;
  logic [1:0]  count;
  logic        push, pop;

  assign op    = s_tdata[1:0];
  assign addr  = s_tdata[9:2];
  assign wdata = s_tdata[41:10];
  assign toff  = addr - A_TIMER0;
  assign tnum  = toff[7:3];
  assign treg  = toff[2:0];

  // address decode
  always_comb begin
    logic ten;
    ten = (addr >= A_TIMER0) && (32'(tnum) < NUM_TIMERS);
    dec.kind  = K_NONE;
    dec.timer = tnum[TW-1:0];
    dec.high  = (addr == A_CNT_HI) || (treg == R_CMP_HI);
    dec.data  = wdata;
    if (op == OP_TICK) begin
      dec.kind = K_TICK;
    end else if (op == OP_READ) begin
      if (addr == A_CAP) dec.kind = K_RD_CAP;
      else if (addr == A_PERIOD) dec.kind = K_RD_PERIOD;
      else if (addr == A_GCFG) dec.kind = K_RD_GCFG;
      else if (addr == A_ISR) dec.kind = K_RD_ISR;
      else if (addr == A_CNT_LO) dec.kind = K_RD_CNT_LO;
      else if (addr == A_CNT_HI) dec.kind = K_RD_CNT_HI;
      else if (ten && treg == R_CFG) dec.kind = K_RD_TCFG;
      else if (ten && treg == R_CMP_LO) dec.kind = K_RD_CMP_LO;
      else if (ten && treg == R_CMP_HI) dec.kind = K_RD_CMP_HI;
    end else if (op == OP_WRITE) begin
      if (addr == A_GCFG) dec.kind = K_WR_GCFG;
      else if (addr == A_ISR) dec.kind = K_WR_ISR;
      else if (addr == A_CNT_LO || addr == A_CNT_HI) dec.kind = K_WR_CNT;
      else if (ten && treg == R_CFG) dec.kind = K_WR_TCFG;
      else if (ten && (treg == R_CMP_LO || treg == R_CMP_HI)) dec.kind = K_WR_CMP;
    end
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = q[rd_ptr];

  // command queue
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= dec;
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

// ===== src/hpet_back.sv =====
// back part: register state, counter, comparators, and output register
`default_nettype none
module hpet_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  hpet_pkg::cmd_t         q_cmd,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [26:0]       cfg_data,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output logic [39:0]            m_tdata
);
  import hpet_pkg::*;

  logic [26:0] tick_period_fs;
  logic [15:0] vendor_id;
  logic        global_enable, legacy_route;
  logic [63:0] main_counter;
  logic [3:0]  tcfg [NUM_TIMERS];
  logic [63:0] comparator [NUM_TIMERS];
  logic [63:0] period [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] pend;
  logic [NUM_TIMERS-1:0] status;
  logic [63:0] cnt_inc;
  logic        go;
  logic [31:0] rdata;
  logic [NUM_TIMERS-1:0] inten;
  logic [NUM_TIMERS-1:0] status_next;
  logic [3:0]  c;

  assign q_ready = !m_tvalid || m_tready;
  assign go      = q_valid && q_ready;
  assign cnt_inc = main_counter + 64'd1;
  assign c       = tcfg[q_cmd.timer];

  // read mux
  always_comb begin
    rdata = '0;
    case (q_cmd.kind)
      K_RD_CAP:    rdata = {vendor_id, 1'b1, 1'b0, 1'b1, 5'(NUM_TIMERS - 1), 8'd1};
      K_RD_PERIOD: rdata = {5'd0, tick_period_fs};
      K_RD_GCFG:   rdata = {30'd0, legacy_route, global_enable};
      K_RD_ISR:    rdata = 32'(status);
      K_RD_CNT_LO: rdata = main_counter[31:0];
      K_RD_CNT_HI: rdata = main_counter[63:32];
      K_RD_TCFG:   rdata = {23'd0, c[3], 2'b00, 2'b11, c[2], c[1], c[0], 1'b0};
      K_RD_CMP_LO: rdata = comparator[q_cmd.timer][31:0];
      K_RD_CMP_HI: rdata = c[3] ? 32'd0 : comparator[q_cmd.timer][63:32];
      default:     rdata = '0;
    endcase
  end

  // status after this beat, feeds irq output
  always_comb begin
    status_next = status;
    for (int n = 0; n < NUM_TIMERS; n++) begin
      inten[n] = tcfg[n][1];
      if (q_cmd.kind == K_TICK && global_enable) begin
        if (tcfg[n][3] ? (cnt_inc[31:0] == comparator[n][31:0])
                       : (cnt_inc == comparator[n]))
          status_next[n] = 1'b1;
      end
    end
    if (q_cmd.kind == K_WR_ISR) status_next = status & ~q_cmd.data[NUM_TIMERS-1:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_period_fs <= 27'd69841279;
      vendor_id      <= 16'd32902;
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_PERIOD) tick_period_fs <= cfg_data;
      else vendor_id <= cfg_data[15:0];
    end
  end

  // register state
  always_ff @(posedge clk) begin
    if (rst) begin
      global_enable <= 1'b0;
      legacy_route  <= 1'b0;
      main_counter  <= '0;
      pend          <= '0;
      status        <= '0;
      for (int n = 0; n < NUM_TIMERS; n++) begin
        tcfg[n]       <= '0;
        comparator[n] <= '1;
        period[n]     <= '0;
      end
    end else if (go) begin
      status <= status_next;
      case (q_cmd.kind)
        K_TICK: begin
          if (global_enable) begin
            main_counter <= cnt_inc;
            for (int n = 0; n < NUM_TIMERS; n++) begin
              if (status_next[n] != status[n] || (tcfg[n][3]
                  ? (cnt_inc[31:0] == comparator[n][31:0]) : (cnt_inc == comparator[n])))
                if (tcfg[n][2]) begin
                  if (tcfg[n][3]) comparator[n] <= {32'd0, comparator[n][31:0] + period[n][31:0]};
                  else comparator[n] <= comparator[n] + period[n];
                end
            end
          end
        end
        K_WR_GCFG: begin
          global_enable <= q_cmd.data[0];
          legacy_route  <= q_cmd.data[1];
        end
        K_WR_CNT: begin
          if (!global_enable) begin
            if (q_cmd.high) main_counter[63:32] <= q_cmd.data;
            else main_counter[31:0] <= q_cmd.data;
          end
        end
        K_WR_TCFG: begin
          tcfg[q_cmd.timer] <= {q_cmd.data[8], q_cmd.data[3], q_cmd.data[2], q_cmd.data[1]};
          if (q_cmd.data[6]) pend[q_cmd.timer] <= 1'b1;
        end
        K_WR_CMP: begin
          if (!(q_cmd.high && c[3])) begin
            if (pend[q_cmd.timer] || !c[2]) begin
              if (q_cmd.high) comparator[q_cmd.timer][63:32] <= q_cmd.data;
              else if (c[3]) comparator[q_cmd.timer] <= {32'd0, q_cmd.data};
              else comparator[q_cmd.timer][31:0] <= q_cmd.data;
            end
            if (pend[q_cmd.timer] || c[2]) begin
              if (q_cmd.high) period[q_cmd.timer][63:32] <= q_cmd.data;
              else if (c[3]) period[q_cmd.timer] <= {32'd0, q_cmd.data};
              else period[q_cmd.timer][31:0] <= q_cmd.data;
            end
            pend[q_cmd.timer] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    logic [2:0] irq;
    irq = '0;
    for (int n = 0; n < NUM_TIMERS && n < 3; n++) begin
      if (status_next[n] && (q_cmd.kind == K_WR_TCFG && q_cmd.timer == TW'(n)
          ? q_cmd.data[2] : inten[n]))
        irq[n] = 1'b1;
    end
    if (go) m_tdata <= {5'd0, irq, rdata};
    if (rst) m_tvalid <= 1'b0;
    else if (go) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
endmodule
`default_nettype wire

// ===== src/hpet_timer_block_unit.sv =====
// top level of the event-timer register block
`default_nettype none
// Event-timer register block with a 64-bit main counter and NUM_TIMERS
// comparator timers. Each input beat is a tick, a 32-bit register read or
// a 32-bit register write; each gives exactly one output beat carrying the
// read data and the interrupt lines after the beat. One beat per cycle is
// sustained while m_tready holds; a beat passes the decode queue, then the
// execute stage that updates all timer state and loads the output register.
module hpet_timer_block_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,  // operation[1:0], dword_address[9:2], write_data[41:10]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // read_data[31:0], irq_lines[34:32]
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [26:0] cfg_data
);
  import hpet_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_cmd;

  hpet_front u_front (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .q_valid, .q_ready, .q_cmd
  );

  hpet_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_cmd,
    .cfg_we, .cfg_index, .cfg_data,
    .m_tvalid, .m_tready, .m_tdata
  );
endmodule
`default_nettype wire

// ===== src/hpet_checker.sv =====
// port-level checker for the event-timer block, bound to the top level
`default_nettype none
module hpet_props (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata
);
  // output beat held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("out beat dropped");
  // accepted input shows a result on the output when the output is free
  a_out: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |-> ##2 m_tvalid) else $error("no result");
  // nothing after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid) else $error("valid after reset");
  // spare output bits stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[39:35] == 5'd0) else $error("pad bits set");
endmodule

bind hpet_timer_block_unit hpet_props u_props (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata
);
`default_nettype wire
